// File: rtl/mexp_pkg.sv
// Shared constants, types and codes of the modular exponentiation block.
package mexp_pkg;

  // Width of modulus, base and residue, and of each exponent.
  localparam int MOD_BITS  = 16;
  localparam int EXP_BITS  = 16;
  localparam int CNT_W     = $clog2(MOD_BITS);
  localparam int BIT_W     = $clog2(EXP_BITS);
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = CFG_IDX_W'(2);

  // Register values after reset.
  localparam logic [MOD_BITS-1:0] RST_MODULUS  = MOD_BITS'(253);
  localparam logic [EXP_BITS-1:0] RST_PUB_EXP  = EXP_BITS'(3);
  localparam logic [EXP_BITS-1:0] RST_PRIV_EXP = EXP_BITS'(147);

  // Operation codes on the input channel.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_END,
    ST_SQ_LD,
    ST_SQ,
    ST_SQ_END,
    ST_MU_LD,
    ST_MU,
    ST_MU_END,
    ST_DONE
  } state_t;

  // Datapath operations.
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED,
    DP_RED_END,
    DP_MUL_LD,
    DP_MUL,
    DP_MUL_END
  } dp_op_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   sel_base;
    logic   exp_shift;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic special;
    logic exp_msb;
  } dp_status_t;

endpackage

// File: rtl/mexp_if.sv
// Valid/ready channel interfaces for input, result and configuration beats.
interface mexp_in_if import mexp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [MOD_BITS-1:0] value;
  logic                last_in;

  modport source (output valid, output op, output value, output last_in, input ready);
  modport sink   (input valid, input op, input value, input last_in, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] residue;
  logic                last_out;

  modport source (output valid, output residue, output last_out, input ready);
  modport sink   (input valid, input residue, input last_out, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MOD_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mexp_datapath.sv
// Datapath: base reduction and shift-and-add modular multiply registers.
module mexp_datapath import mexp_pkg::*; (
  input  logic                clk,
  input  dp_cmd_t             cmd,
  input  logic                in_op,
  input  logic [MOD_BITS-1:0] in_value,
  input  logic                in_last,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic [EXP_BITS-1:0] pub_exp,
  input  logic [EXP_BITS-1:0] priv_exp,
  output dp_status_t          status,
  output logic [MOD_BITS-1:0] residue,
  output logic                last
);

  logic [MOD_BITS-1:0] base_r, base_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] r_r, r_nxt;
  logic [MOD_BITS-1:0] mb_r, mb_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic                zexp_r, zexp_nxt;
  logic                zmod_r, zmod_nxt;
  logic                last_r, last_nxt;

  logic [EXP_BITS-1:0] exp_sel;
  logic [MOD_BITS:0]   mod_ext;
  logic [MOD_BITS:0]   red_t;
  logic [MOD_BITS-1:0] red_q;
  logic [MOD_BITS:0]   dbl_t;
  logic [MOD_BITS-1:0] dbl_q;
  logic [MOD_BITS:0]   sum_t;
  logic [MOD_BITS-1:0] sum_q;

  assign exp_sel = (in_op == OP_DECRYPT) ? priv_exp : pub_exp;
  assign mod_ext = {1'b0, modulus};

  // One restoring step of base mod modulus: shift in the next base bit.
  always_comb begin
    red_t = {acc_r, base_r[MOD_BITS-1]};
    red_q = (red_t >= mod_ext) ? MOD_BITS'(red_t - mod_ext) : red_t[MOD_BITS-1:0];
  end

  // One step of the interleaved multiply: double, then add r when the bit is set.
  always_comb begin
    dbl_t = {acc_r, 1'b0};
    dbl_q = (dbl_t >= mod_ext) ? MOD_BITS'(dbl_t - mod_ext) : dbl_t[MOD_BITS-1:0];
    sum_t = {1'b0, dbl_q} + (mb_r[MOD_BITS-1] ? {1'b0, r_r} : '0);
    sum_q = (sum_t >= mod_ext) ? MOD_BITS'(sum_t - mod_ext) : sum_t[MOD_BITS-1:0];
  end

  // Register updates per command.
  always_comb begin
    base_nxt = base_r;
    acc_nxt  = acc_r;
    r_nxt    = r_r;
    mb_nxt   = mb_r;
    exp_nxt  = exp_r;
    zexp_nxt = zexp_r;
    zmod_nxt = zmod_r;
    last_nxt = last_r;
    case (cmd.op)
      DP_LOAD: begin
        base_nxt = in_value;
        acc_nxt  = '0;
        exp_nxt  = exp_sel;
        zexp_nxt = (exp_sel == '0);
        zmod_nxt = (modulus == '0);
        last_nxt = in_last;
      end
      DP_RED: begin
        acc_nxt  = red_q;
        base_nxt = {base_r[MOD_BITS-2:0], 1'b0};
      end
      DP_RED_END: begin
        base_nxt = acc_r;
        r_nxt    = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      end
      DP_MUL_LD: begin
        acc_nxt = '0;
        mb_nxt  = cmd.sel_base ? base_r : r_r;
      end
      DP_MUL: begin
        acc_nxt = sum_q;
        mb_nxt  = {mb_r[MOD_BITS-2:0], 1'b0};
      end
      DP_MUL_END: begin
        r_nxt = acc_r;
      end
      default: begin
      end
    endcase
    if (cmd.exp_shift) begin
      exp_nxt = {exp_r[EXP_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    r_r    <= r_nxt;
    mb_r   <= mb_nxt;
    exp_r  <= exp_nxt;
    zexp_r <= zexp_nxt;
    zmod_r <= zmod_nxt;
    last_r <= last_nxt;
  end

  // A zero exponent gives one; otherwise a zero modulus gives zero.
  assign status.special = zexp_r | zmod_r;
  assign status.exp_msb = exp_r[EXP_BITS-1];
  assign residue = zexp_r ? MOD_BITS'(1) : (zmod_r ? '0 : r_r);
  assign last    = last_r;

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences reduction, square and multiply steps per item.
module mexp_ctrl import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_free,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_ready,
  output logic       out_load
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             cnt_end;
  logic             bit_end;

  assign cnt_end = (cnt_r == CNT_W'(MOD_BITS - 1));
  assign bit_end = (bit_r == BIT_W'(EXP_BITS - 1));

  // Next state and step counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (status.special) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_end) begin
            state_nxt = ST_RED_END;
          end
        end
      end
      ST_RED_END: begin
        bit_nxt   = '0;
        state_nxt = ST_SQ_LD;
      end
      ST_SQ_LD: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_end) begin
          state_nxt = ST_SQ_END;
        end
      end
      ST_SQ_END: begin
        if (status.exp_msb) begin
          state_nxt = ST_MU_LD;
        end else if (bit_end) begin
          state_nxt = ST_DONE;
        end else begin
          bit_nxt   = bit_r + 1'b1;
          state_nxt = ST_SQ_LD;
        end
      end
      ST_MU_LD: begin
        cnt_nxt   = '0;
        state_nxt = ST_MU;
      end
      ST_MU: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_end) begin
          state_nxt = ST_MU_END;
        end
      end
      ST_MU_END: begin
        if (bit_end) begin
          state_nxt = ST_DONE;
        end else begin
          bit_nxt   = bit_r + 1'b1;
          state_nxt = ST_SQ_LD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd.op        = DP_NOP;
    cmd.sel_base  = 1'b0;
    cmd.exp_shift = 1'b0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LOAD;
        end
      end
      ST_RED: begin
        if (!status.special) begin
          cmd.op = DP_RED;
        end
      end
      ST_RED_END: begin
        cmd.op = DP_RED_END;
      end
      ST_SQ_LD: begin
        cmd.op = DP_MUL_LD;
      end
      ST_SQ: begin
        cmd.op = DP_MUL;
      end
      ST_SQ_END: begin
        cmd.op        = DP_MUL_END;
        cmd.exp_shift = !status.exp_msb;
      end
      ST_MU_LD: begin
        cmd.op       = DP_MUL_LD;
        cmd.sel_base = 1'b1;
      end
      ST_MU: begin
        cmd.op = DP_MUL;
      end
      ST_MU_END: begin
        cmd.op        = DP_MUL_END;
        cmd.exp_shift = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

// File: rtl/modular_exponentiation.sv
// Modular exponentiation: one beat in gives value to the selected exponent modulo
// the configured modulus. An item first reduces the base with one restoring step a
// cycle, then walks all 16 exponent bits from the top, each bit taking a modular
// square and, for a set bit, a modular multiply; both run on one shift-and-add
// unit that handles one multiplier bit per cycle. A zero exponent or a zero modulus
// skips the reduction and the exponent walk. Items are worked one at a time; the
// next beat is taken as soon as the result sits in the output register.
// Configuration writes are taken at any time and must only be issued while idle.
module modular_exponentiation import mexp_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  mexp_in_if.sink       in_ch,
  mexp_out_if.source    out_ch,
  mexp_cfg_if.sink      cfg_ch
);

  logic [MOD_BITS-1:0] modulus_r;
  logic [EXP_BITS-1:0] pub_exp_r;
  logic [EXP_BITS-1:0] priv_exp_r;
  logic                out_valid_r;
  logic [MOD_BITS-1:0] out_residue_r;
  logic                out_last_r;

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic                in_ready;
  logic                out_load;
  logic                out_free;
  logic [MOD_BITS-1:0] dp_residue;
  logic                dp_last;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= RST_MODULUS;
      pub_exp_r  <= RST_PUB_EXP;
      priv_exp_r <= RST_PRIV_EXP;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MODULUS:  modulus_r  <= cfg_ch.data;
        CFG_PUB_EXP:  pub_exp_r  <= EXP_BITS'(cfg_ch.data);
        CFG_PRIV_EXP: priv_exp_r <= EXP_BITS'(cfg_ch.data);
        default: begin
        end
      endcase
    end
  end

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_load (out_load)
  );

  mexp_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_op    (in_ch.op),
    .in_value (in_ch.value),
    .in_last  (in_ch.last_in),
    .modulus  (modulus_r),
    .pub_exp  (pub_exp_r),
    .priv_exp (priv_exp_r),
    .status   (status),
    .residue  (dp_residue),
    .last     (dp_last)
  );

  assign in_ch.ready = in_ready;

  // Output register: holds a finished result until its beat is taken.
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_residue_r <= dp_residue;
      out_last_r    <= dp_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.residue  = out_residue_r;
  assign out_ch.last_out = out_last_r;

  // An accepted beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again right after an accepted beat");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while occupied");

  // A loaded residue is reduced, except the one from a zero exponent or a zero modulus.
  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ((dp_residue < modulus_r) || (dp_residue == MOD_BITS'(1)) ||
                  (dp_residue == '0)))
    else $error("residue not below modulus");

endmodule

// File: tb/modular_exponentiation_test.sv
// Self-checking testbench for the modular exponentiation block with its own residue predictor.
module modular_exponentiation_test import mexp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  HALF_PERIOD   = 6;
  localparam int  RESET_CYCLES  = 6;
  localparam int  MAX_IDLE      = 12;
  localparam int  IDLE_GUARD    = 8;
  localparam int  TAIL_CYCLES   = 700;
  localparam int  PHASES        = 12;
  localparam int  PHASE_ITEMS   = 150;
  localparam int  HOLD_AT       = 500;
  localparam int  HOLD_CYCLES   = 3000;
  localparam longint TIMEOUT_NS = 80_000_000;

  // Index that maps to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed script: a register write or an input beat.
  // For input beats, data is the value; typed rows carry their known residue.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [MOD_BITS-1:0]  data;
    logic                 op;
    logic                 last;
    logic                 typed;
    logic [MOD_BITS-1:0]  residue;
  } script_row_t;

  typedef struct {
    logic [MOD_BITS-1:0] residue;
    logic                last;
  } result_t;

  localparam int SCRIPT_LEN = 29;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Reset settings: modulus 253, public 3, private 147.
    '{ROW_ITEM, '0, 16'd0,         OP_ENCRYPT, 1'b0, 1'b1, 16'd0},
    '{ROW_ITEM, '0, 16'd1,         OP_ENCRYPT, 1'b1, 1'b1, 16'd1},
    '{ROW_ITEM, '0, 16'd65535,     OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd2,         OP_DECRYPT, 1'b1, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd252,       OP_DECRYPT, 1'b0, 1'b0, 16'd0},
    // Zero public exponent gives one, even for a zero base.
    '{ROW_CFG,  CFG_PUB_EXP, 16'd0, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd12345,     OP_ENCRYPT, 1'b1, 1'b1, 16'd1},
    '{ROW_ITEM, '0, 16'd0,         OP_ENCRYPT, 1'b0, 1'b1, 16'd1},
    // Largest private exponent.
    '{ROW_CFG,  CFG_PRIV_EXP, 16'd65535, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd65535,     OP_DECRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd7,         OP_DECRYPT, 1'b1, 1'b0, 16'd0},
    // Modulus of one: zero exponent still gives one, otherwise zero.
    '{ROW_CFG,  CFG_MODULUS, 16'd1, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd40000,     OP_ENCRYPT, 1'b0, 1'b1, 16'd1},
    '{ROW_ITEM, '0, 16'd9,         OP_DECRYPT, 1'b1, 1'b1, 16'd0},
    // Modulus of zero.
    '{ROW_CFG,  CFG_MODULUS, 16'd0, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd5,         OP_DECRYPT, 1'b0, 1'b1, 16'd0},
    '{ROW_ITEM, '0, 16'd5,         OP_ENCRYPT, 1'b1, 1'b1, 16'd1},
    // A write to the unused index leaves every register alone.
    '{ROW_CFG,  CFG_UNUSED_IDX, 16'hABCD, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd3,         OP_DECRYPT, 1'b0, 1'b1, 16'd0},
    // Largest modulus, with bases at and just under it.
    '{ROW_CFG,  CFG_MODULUS, 16'd65535, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd65535,     OP_DECRYPT, 1'b1, 1'b1, 16'd0},
    '{ROW_ITEM, '0, 16'd65534,     OP_ENCRYPT, 1'b0, 1'b1, 16'd1},
    '{ROW_CFG,  CFG_PUB_EXP, 16'd65535, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd65534,     OP_ENCRYPT, 1'b1, 1'b1, 16'd65534},
    '{ROW_ITEM, '0, 16'd2,         OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    // Smallest proper modulus.
    '{ROW_CFG,  CFG_MODULUS, 16'd2, OP_ENCRYPT, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 16'd3,         OP_ENCRYPT, 1'b1, 1'b1, 16'd1},
    '{ROW_ITEM, '0, 16'd65535,     OP_DECRYPT, 1'b0, 1'b1, 16'd1},
    '{ROW_ITEM, '0, 16'd65534,     OP_DECRYPT, 1'b1, 1'b1, 16'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mexp_in_if  in_bus ();
  mexp_out_if out_bus ();
  mexp_cfg_if cfg_bus ();

  modular_exponentiation uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Predictor copy of the registers.
  logic [MOD_BITS-1:0] modulus_q   = RST_MODULUS;
  logic [EXP_BITS-1:0] pub_exp_q   = RST_PUB_EXP;
  logic [EXP_BITS-1:0] priv_exp_q  = RST_PRIV_EXP;

  result_t pending_results [$];
  int      items_sent;
  int      results_seen;
  int      failures;
  int      cfg_writes;
  int      settings_used;

  always #HALF_PERIOD clk = ~clk;

  // Square-and-multiply from the top exponent bit, reducing after every product.
  function automatic logic [MOD_BITS-1:0] modexp_residue(input logic op,
                                                         input logic [MOD_BITS-1:0] base);
    logic [EXP_BITS-1:0] power;
    logic [31:0]         acc;
    logic [31:0]         reduced;
    power = (op == OP_DECRYPT) ? priv_exp_q : pub_exp_q;
    if (power == '0) return MOD_BITS'(1);
    if (modulus_q == '0) return '0;
    reduced = 32'(base) % 32'(modulus_q);
    acc = 32'd1 % 32'(modulus_q);
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % 32'(modulus_q);
      if (power[i]) acc = (acc * reduced) % 32'(modulus_q);
    end
    return acc[MOD_BITS-1:0];
  endfunction

  // Exponent with weight on zero, one and all ones.
  function automatic logic [EXP_BITS-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return EXP_BITS'(1);
      2:       return '1;
      default: return EXP_BITS'($urandom);
    endcase
  endfunction

  // Base value: edges, under the modulus, or anywhere in the field.
  function automatic logic [MOD_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return MOD_BITS'(1);
      2:       return modulus_q - MOD_BITS'(1);
      3:       return '1;
      4, 5:    return MOD_BITS'($urandom_range(0, (modulus_q == '0) ? 0 : modulus_q - 1));
      default: return MOD_BITS'($urandom);
    endcase
  endfunction

  // Register write beat; valid is left high so back-to-back writes leave no gap between beats.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [MOD_BITS-1:0]  data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_MODULUS:  modulus_q  = data;
      CFG_PUB_EXP:  pub_exp_q  = data;
      CFG_PRIV_EXP: priv_exp_q = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Input beat after an optional gap; the expected result is queued on acceptance.
  task automatic send_item(input logic op, input logic [MOD_BITS-1:0] value,
                           input logic last, input logic typed,
                           input logic [MOD_BITS-1:0] typed_residue, input int gap);
    result_t want;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.op      <= op;
    in_bus.value   <= value;
    in_bus.last_in <= last;
    do @(posedge clk); while (!in_bus.ready);
    want.residue = typed ? typed_residue : modexp_residue(op, value);
    want.last    = last;
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Stop offering beats and wait until the block has nothing left in flight.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  // Stimulus: reset, directed script, then random phases under changing settings.
  initial begin : stimulus
    logic [MOD_BITS-1:0] new_mod;
    logic [EXP_BITS-1:0] new_pub;
    logic [EXP_BITS-1:0] new_priv;
    bit                  calm;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.op      <= OP_ENCRYPT;
    in_bus.value   <= '0;
    in_bus.last_in <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_MODULUS;
    cfg_bus.data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script.
    settings_used = 1;
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        drain();
        write_register(SCRIPT[r].index, SCRIPT[r].data);
        cfg_bus.valid <= 1'b0;
        settings_used++;
      end else begin
        send_item(SCRIPT[r].op, SCRIPT[r].data, SCRIPT[r].last, SCRIPT[r].typed,
                  SCRIPT[r].residue, $urandom_range(0, MAX_IDLE));
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          new_mod = '1; new_pub = '1; new_priv = '0;
        end
        1: begin
          new_mod = MOD_BITS'(2); new_pub = EXP_BITS'(1); new_priv = '1;
        end
        2: begin
          new_mod = MOD_BITS'(1); new_pub = pick_exponent(); new_priv = pick_exponent();
        end
        3: begin
          new_mod = '0; new_pub = pick_exponent(); new_priv = pick_exponent();
        end
        4: begin
          new_mod = MOD_BITS'(65521); new_pub = EXP_BITS'(3); new_priv = EXP_BITS'($urandom);
        end
        default: begin
          new_mod  = ($urandom_range(0, 2) == 0) ? MOD_BITS'($urandom_range(2, 255))
                                                 : MOD_BITS'($urandom_range(2, 65535));
          new_pub  = pick_exponent();
          new_priv = pick_exponent();
        end
      endcase
      if (p % 3 == 0) write_register(CFG_UNUSED_IDX, MOD_BITS'($urandom));
      write_register(CFG_PRIV_EXP, new_priv);
      write_register(CFG_MODULUS, new_mod);
      write_register(CFG_PUB_EXP, new_pub);
      cfg_bus.valid <= 1'b0;
      settings_used++;

      // Every fourth phase the sender offers beats back to back.
      calm = (p % 4 == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(logic'($urandom_range(0, 1)), pick_value(),
                  ($urandom_range(0, 7) == 0), 1'b0, '0,
                  calm ? 0 : $urandom_range(0, MAX_IDLE));
      end
    end

    // Wind down and report.
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d input beats under %0d register settings (%0d register writes).",
             items_sent, settings_used, cfg_writes);
    $display("Checked %0d result beats, %0d mismatching.", results_seen, failures);
    if (failures == 0) begin
      $display("modular_exponentiation_test: PASS");
    end else begin
      $display("modular_exponentiation_test: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and a field-by-field check of each beat.
  initial begin : result_sink
    int      wait_cycles;
    bit      calm;
    bit      held;
    result_t want;
    out_bus.ready <= 1'b0;
    calm = 1'b0;
    held = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (results_seen % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      // Hold the output long enough for the block to back up into its input.
      if (results_seen == HOLD_AT && !held) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: residue %0d, last_out %0d",
               out_bus.residue, out_bus.last_out);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.residue !== want.residue) begin
          $error("residue: expected %0d, got %0d", want.residue, out_bus.residue);
          failures++;
        end
        if (out_bus.last_out !== want.last) begin
          $error("last_out: expected %0d, got %0d", want.last, out_bus.last_out);
          failures++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("modular_exponentiation_test: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_test.sv
